// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge, off during reset
`define MGLC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge, off during reset
`define MGLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mglc_pkg.sv =====
`default_nettype none

package mglc_pkg;

  // Operand and result value width
  localparam int unsigned DataW = 31;
  localparam int unsigned StatusW = 3;

  // Run length limits
  localparam int unsigned MaxOperands = 6;
  localparam int unsigned MinOperands = 2;
  localparam int unsigned CntW = $clog2(MaxOperands + 2);

  // Result status codes
  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_TOO_FEW  = 3'd1;
  localparam logic [StatusW-1:0] ST_TOO_MANY = 3'd2;
  localparam logic [StatusW-1:0] ST_ZERO     = 3'd3;
  localparam logic [StatusW-1:0] ST_OVERFLOW = 3'd4;

  typedef struct packed {
    logic [DataW-1:0] operand;
    logic             last_operand;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0]   gcd_value;
    logic [DataW-1:0]   lcm_value;
    logic [StatusW-1:0] status;
  } result_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quotient;
    logic [DataW-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/mglc_div.sv =====
`default_nettype none

// Restoring divider: one quotient bit per cycle, done pulses after DataW steps.
// The divisor must be non-zero.
module mglc_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mglc_pkg::div_req_t req_i,
  output mglc_pkg::div_rsp_t      rsp_o
);
  import mglc_pkg::*;

  localparam int unsigned StepW = $clog2(DataW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quot_q, quot_d;
  logic [DataW-1:0] dsr_q, dsr_d;
  logic [DataW:0]   shifted;
  logic [DataW:0]   diff;

  // Shift in the next dividend bit and try the subtraction
  assign shifted = {rem_q, quot_q[DataW-1]};
  assign diff    = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quot_d = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[DataW]) begin
        rem_d  = diff[DataW-1:0];
        quot_d = {quot_q[DataW-2:0], 1'b1};
      end else begin
        rem_d  = shifted[DataW-1:0];
        quot_d = {quot_q[DataW-2:0], 1'b0};
      end
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dsr_q  <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quot_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

// ===== rtl/multi_operand_gcd_lcm_core.sv =====
`default_nettype none

// Running GCD and LCM over a run of 2 to 6 operands, one word per start pulse,
// the last word of a run marked. busy is high while a word is being worked
// on; a word is taken when start is high and busy is low. Every Euclid
// remainder step runs on one shared restoring divider: a word runs the
// remainder steps of the GCD update, then those of the GCD for the LCM
// update, then one division of the LCM; a word after an error or of value
// zero skips them all. After the last word the result is shown for exactly
// one cycle with result_valid_o high and cannot be held off: the receiver
// must take it then.
module multi_operand_gcd_lcm_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire mglc_pkg::item_t item_i,
  output logic                 result_valid_o,
  output mglc_pkg::result_t    result_o
);
  import mglc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GLOOP = 4'd1;
  localparam logic [3:0] S_GWAIT = 4'd2;
  localparam logic [3:0] S_LLOOP = 4'd3;
  localparam logic [3:0] S_LWAIT = 4'd4;
  localparam logic [3:0] S_QWAIT = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

  logic [3:0]         state_q, state_d;
  logic [DataW-1:0]   gcd_q, gcd_d;
  logic [DataW-1:0]   lcm_q, lcm_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [StatusW-1:0] err_q, err_d;
  logic               valid_q, valid_d;
  result_t            res_q, res_d;
  logic [DataW-1:0]   a_q, a_d;
  logic [DataW-1:0]   b_q, b_d;
  logic [DataW-1:0]   x_q, x_d;
  logic               last_q, last_d;
  logic [2*DataW-1:0] prod_q, prod_d;
  logic [CntW-1:0]    cnt_inc;
  logic [StatusW-1:0] status;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  mglc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Saturating operand count and final status
  always_comb begin
    cnt_inc = cnt_q;
    if (cnt_q <= CntW'(MaxOperands)) begin
      cnt_inc = cnt_q + CntW'(1);
    end
    if (cnt_inc < CntW'(MinOperands)) begin
      status = ST_TOO_FEW;
    end else if (cnt_inc > CntW'(MaxOperands)) begin
      status = ST_TOO_MANY;
    end else begin
      status = err_q;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    gcd_d   = gcd_q;
    lcm_d   = lcm_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    valid_d = 1'b0;
    res_d   = res_q;
    a_d     = a_q;
    b_d     = b_q;
    x_d     = x_q;
    last_d  = last_q;
    prod_d  = prod_q;
    div_req = '{start: 1'b0, dividend: a_q, divisor: b_q};
    case (state_q)
      S_IDLE: begin
        if (start) begin
          x_d    = item_i.operand;
          last_d = item_i.last_operand;
          a_d    = (cnt_q == '0) ? item_i.operand : gcd_q;
          b_d    = item_i.operand;
          if (cnt_q == '0) begin
            gcd_d = item_i.operand;
          end
          if (err_q != ST_OK) begin
            state_d = S_FIN;
          end else if (item_i.operand == '0) begin
            err_d   = ST_ZERO;
            state_d = S_FIN;
          end else begin
            state_d = S_GLOOP;
          end
        end
      end
      S_GLOOP: begin
        if (b_q == '0) begin
          gcd_d   = a_q;
          a_d     = lcm_q;
          b_d     = x_q;
          state_d = S_LLOOP;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (div_rsp.done) begin
          a_d     = b_q;
          b_d     = div_rsp.remainder;
          state_d = S_GLOOP;
        end
      end
      S_LLOOP: begin
        div_req.start = 1'b1;
        if (b_q == '0) begin
          // divide the running LCM by gcd(lcm, x)
          div_req.dividend = lcm_q;
          div_req.divisor  = a_q;
          state_d          = S_QWAIT;
        end else begin
          state_d = S_LWAIT;
        end
      end
      S_LWAIT: begin
        if (div_rsp.done) begin
          a_d     = b_q;
          b_d     = div_rsp.remainder;
          state_d = S_LLOOP;
        end
      end
      S_QWAIT: begin
        if (div_rsp.done) begin
          prod_d  = {{DataW{1'b0}}, div_rsp.quotient} * {{DataW{1'b0}}, x_q};
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (prod_q[2*DataW-1:DataW] != '0) begin
          err_d = ST_OVERFLOW;
        end else begin
          lcm_d = prod_q[DataW-1:0];
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        cnt_d   = cnt_inc;
        state_d = S_IDLE;
        if (last_q) begin
          valid_d          = 1'b1;
          res_d.status     = status;
          res_d.gcd_value  = (status == ST_OK) ? gcd_q : '0;
          res_d.lcm_value  = (status == ST_OK) ? lcm_q : '0;
          gcd_d            = '0;
          lcm_d            = DataW'(1);
          cnt_d            = '0;
          err_d            = ST_OK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Clear run state and control under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      gcd_q   <= '0;
      lcm_q   <= DataW'(1);
      cnt_q   <= '0;
      err_q   <= ST_OK;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      gcd_q   <= gcd_d;
      lcm_q   <= lcm_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    a_q    <= a_d;
    b_q    <= b_d;
    x_q    <= x_d;
    last_q <= last_d;
    prod_q <= prod_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/mglc_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the core
module mglc_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              result_valid_o,
  input wire mglc_pkg::result_t result_o
);
  import mglc_pkg::*;

  logic item_taken;
  logic err_result;
  logic ok_result;

  assign item_taken = start && !busy;
  assign err_result = result_valid_o && (result_o.status != ST_OK);
  assign ok_result  = result_valid_o && (result_o.status == ST_OK);

  // An accepted word keeps the core busy in the next cycle
  `MGLC_ASSERT_NEXT(a_taken_busy, clk_i, rst_ni, item_taken, busy)
  // A result is shown for one cycle only
  `MGLC_ASSERT_NEXT(a_single_word, clk_i, rst_ni, result_valid_o, !result_valid_o)
  // A result only ever follows work in progress
  `MGLC_ASSERT_NOW(a_after_work, clk_i, rst_ni, result_valid_o, $past(busy))
  // Error results carry zero values
  `MGLC_ASSERT_NOW(a_err_zero, clk_i, rst_ni, err_result,
    (result_o.gcd_value == '0) && (result_o.lcm_value == '0))
  // Good results carry non-zero values
  `MGLC_ASSERT_NOW(a_ok_nonzero, clk_i, rst_ni, ok_result,
    (result_o.gcd_value != '0) && (result_o.lcm_value != '0))

endmodule

bind multi_operand_gcd_lcm_core mglc_checker u_mglc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

`default_nettype wire
